// ===== rtl/rbht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbht_pkg: shared types, constants and helpers of the ray box hit test unit
// Holds the pipeline stage map, the per-axis and per-face pipeline records
// and the radix-2 division step used by the divider stages.
// ----------------------------------------------------------------------------
package rbht_pkg;

  localparam int NUM_AXES   = 3;
  localparam int NUM_FACES  = 2 * NUM_AXES;
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int DIV_W      = COORD_W + FRAC_BITS;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;
  localparam int HALF_W     = DIV_W / 2;
  localparam int PART_W     = COORD_W + HALF_W;
  localparam int PROD_W     = 64;
  localparam int OFF_W      = PROD_W - FRAC_BITS + 1;
  localparam int BIG_BIT    = 38;

  // Pipeline stage map.
  localparam int STG_IN     = 0;
  localparam int STG_PRE    = 1;
  localparam int STG_ABS    = 2;
  localparam int STG_MUL    = STG_ABS + DIV_STAGES + 1;
  localparam int STG_SUM    = STG_MUL + 1;
  localparam int STG_OFF    = STG_SUM + 1;
  localparam int STG_OUT    = STG_OFF + 1;
  localparam int NUM_STAGES = STG_OUT + 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Per-axis data that rides along with every item.
  typedef struct packed {
    logic [COORD_W-1:0]       ad;      // magnitude of the direction component
    logic                     dneg;    // direction component is negative
    logic                     dz;      // direction component is zero
    logic signed [DIFF_W-1:0] lo_off;  // box_min - origin
    logic signed [DIFF_W-1:0] hi_off;  // box_max - origin
  } axis_t;

  // Per-face divider state: partial remainder and dividend/quotient shifter.
  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [DIV_W-1:0]   dvd;
    logic               neg;
    logic               dz;
  } face_div_t;

  // Restoring division, DIV_STEPS quotient bits per call.
  function automatic face_div_t div_step(face_div_t fin, logic [COORD_W-1:0] divisor);
    face_div_t          r;
    logic [COORD_W:0]   part;
    r = fin;
    for (int i = 0; i < DIV_STEPS; i++) begin
      part = {r.rem, r.dvd[DIV_W-1]};
      if (part >= {1'b0, divisor}) begin
        part  = part - {1'b0, divisor};
        r.dvd = {r.dvd[DIV_W-2:0], 1'b1};
      end else begin
        r.dvd = {r.dvd[DIV_W-2:0], 1'b0};
      end
      r.rem = part[COORD_W-1:0];
    end
    return r;
  endfunction

  // The j-th (0 or 1) axis other than axis a, in cyclic order.
  function automatic logic [1:0] other_axis(logic [1:0] a, logic j);
    logic [2:0] s;
    s = {1'b0, a} + 3'd1 + {2'b0, j};
    if (s >= 3'(NUM_AXES)) begin
      s = s - 3'(NUM_AXES);
    end
    return s[1:0];
  endfunction

endpackage

// ===== rtl/ray_box_hit_test_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_hit_test_unit: streaming ray versus axis-aligned box hit test
// Fully pipelined: one ray/box word per cycle while the output is not stalled, one hit flag per word.
// ----------------------------------------------------------------------------
// Each input word carries a ray (origin, direction) and a box (lower and
// upper corner) in signed Q16.16. The unit tests all six face planes: for a
// face it forms t = (plane - origin) / direction truncated toward zero, and
// counts the face as struck when t is not negative and the point on the ray
// at t lies inclusively inside the box on the two other axes. Faces whose
// direction component is zero are skipped. The result word is a single hit
// flag. While the output is not stalled the unit sustains one word per cycle;
// from acceptance to the output a word passes one input register,
// two setup stages, 24 divider stages that retire two quotient bits each on
// six parallel dividers, then multiply, sum, offset and compare stages. A
// stall on the output holds only the stages that are occupied, so bubbles
// collapse and the input keeps accepting words until the pipeline is full.
module ray_box_hit_test_unit
  import rbht_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  coord_t origin_x_i,
  input  coord_t origin_y_i,
  input  coord_t origin_z_i,
  input  coord_t dir_x_i,
  input  coord_t dir_y_i,
  input  coord_t dir_z_i,
  input  coord_t box_min_x_i,
  input  coord_t box_min_y_i,
  input  coord_t box_min_z_i,
  input  coord_t box_max_x_i,
  input  coord_t box_max_y_i,
  input  coord_t box_max_z_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output logic   hit_o
);

  // --------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or its successor advances.
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= (adv & {valid_q[NUM_STAGES-2:0], in_valid_i}) | (~adv & valid_q);
    end
  end

  assign in_stall_o  = !adv[STG_IN];
  assign out_valid_o = valid_q[STG_OUT];

  // --------------------------------------------------------------------------
  // Input register.
  // --------------------------------------------------------------------------
  coord_t org_q [NUM_AXES];
  coord_t dir_q [NUM_AXES];
  coord_t lo_q  [NUM_AXES];
  coord_t hi_q  [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (adv[STG_IN]) begin
      org_q[0] <= origin_x_i;
      org_q[1] <= origin_y_i;
      org_q[2] <= origin_z_i;
      dir_q[0] <= dir_x_i;
      dir_q[1] <= dir_y_i;
      dir_q[2] <= dir_z_i;
      lo_q[0]  <= box_min_x_i;
      lo_q[1]  <= box_min_y_i;
      lo_q[2]  <= box_min_z_i;
      hi_q[0]  <= box_max_x_i;
      hi_q[1]  <= box_max_y_i;
      hi_q[2]  <= box_max_z_i;
    end
  end

  // --------------------------------------------------------------------------
  // Setup: direction magnitudes, box extents relative to the origin, and the
  // signed distance from the origin to each face plane.
  // --------------------------------------------------------------------------
  axis_t                    ax1_d   [NUM_AXES];
  axis_t                    ax1_q   [NUM_AXES];
  logic signed [DIFF_W-1:0] diff1_d [NUM_FACES];
  logic signed [DIFF_W-1:0] diff1_q [NUM_FACES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      ax1_d[a].ad     = dir_q[a][COORD_W-1] ? $unsigned(-dir_q[a]) : $unsigned(dir_q[a]);
      ax1_d[a].dneg   = dir_q[a][COORD_W-1];
      ax1_d[a].dz     = (dir_q[a] == '0);
      ax1_d[a].lo_off = $signed({lo_q[a][COORD_W-1], lo_q[a]} -
                                {org_q[a][COORD_W-1], org_q[a]});
      ax1_d[a].hi_off = $signed({hi_q[a][COORD_W-1], hi_q[a]} -
                                {org_q[a][COORD_W-1], org_q[a]});
    end
    for (int f = 0; f < NUM_FACES; f++) begin
      // Even faces sit on the lower corner, odd faces on the upper corner.
      diff1_d[f] = (f % 2 == 1) ? ax1_d[f/2].hi_off : ax1_d[f/2].lo_off;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_PRE]) begin
      ax1_q   <= ax1_d;
      diff1_q <= diff1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider load and divider stages. Signs are handled apart: t is not
  // negative when the signs agree or the quotient magnitude is zero.
  // --------------------------------------------------------------------------
  face_div_t fd0_d  [NUM_FACES];
  axis_t     axd_q  [DIV_STAGES+1][NUM_AXES];
  face_div_t fd_q   [DIV_STAGES+1][NUM_FACES];
  face_div_t fdn_d  [DIV_STAGES][NUM_FACES];

  always_comb begin
    logic [COORD_W-1:0] mag;
    for (int f = 0; f < NUM_FACES; f++) begin
      mag = diff1_q[f][DIFF_W-1] ? COORD_W'(-diff1_q[f]) : diff1_q[f][COORD_W-1:0];
      fd0_d[f].rem = '0;
      fd0_d[f].dvd = {mag, FRAC_BITS'(0)};
      fd0_d[f].neg = diff1_q[f][DIFF_W-1] ^ ax1_q[f/2].dneg;
      fd0_d[f].dz  = ax1_q[f/2].dz;
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int f = 0; f < NUM_FACES; f++) begin
        fdn_d[s][f] = div_step(fd_q[s][f], axd_q[s][f/2].ad);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_ABS]) begin
      axd_q[0] <= ax1_q;
      fd_q[0]  <= fd0_d;
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      if (adv[STG_ABS+s]) begin
        axd_q[s] <= axd_q[s-1];
        fd_q[s]  <= fdn_d[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Offset multiply: direction component times t, split at the middle of t
  // into two partial products per other axis.
  // --------------------------------------------------------------------------
  axis_t             axm_q  [3][NUM_AXES];
  logic [PART_W-1:0] ph_d   [NUM_FACES][2];
  logic [PART_W-1:0] pl_d   [NUM_FACES][2];
  logic [PART_W-1:0] ph_q   [NUM_FACES][2];
  logic [PART_W-1:0] pl_q   [NUM_FACES][2];
  logic              ok_d   [NUM_FACES];
  logic              ok_q   [3][NUM_FACES];

  always_comb begin
    logic [DIV_W-1:0]   quo;
    logic [COORD_W-1:0] adb;
    for (int f = 0; f < NUM_FACES; f++) begin
      quo      = fd_q[DIV_STAGES][f].dvd;
      ok_d[f]  = !fd_q[DIV_STAGES][f].dz && (!fd_q[DIV_STAGES][f].neg || quo == '0);
      for (int j = 0; j < 2; j++) begin
        adb        = axd_q[DIV_STAGES][other_axis(2'(f / 2), 1'(j))].ad;
        ph_d[f][j] = {HALF_W'(0), adb} * {COORD_W'(0), quo[DIV_W-1:HALF_W]};
        pl_d[f][j] = {HALF_W'(0), adb} * {COORD_W'(0), quo[HALF_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_MUL]) begin
      axm_q[0] <= axd_q[DIV_STAGES];
      ok_q[0]  <= ok_d;
      ph_q     <= ph_d;
      pl_q     <= pl_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sum the partial products; a high part at or above 2^38 puts the point
  // far outside any box.
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] prod_d [NUM_FACES][2];
  logic [PROD_W-1:0] prod_q [NUM_FACES][2];
  logic              big_d  [NUM_FACES][2];
  logic              big_q  [2][NUM_FACES][2];

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      for (int j = 0; j < 2; j++) begin
        prod_d[f][j] = (PROD_W'(ph_q[f][j]) << HALF_W) + PROD_W'(pl_q[f][j]);
        big_d[f][j]  = (ph_q[f][j][PART_W-1:BIG_BIT] != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_SUM]) begin
      axm_q[1]  <= axm_q[0];
      ok_q[1]   <= ok_q[0];
      big_q[0]  <= big_d;
      prod_q    <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Apply the direction sign and drop the fraction, rounding toward minus
  // infinity.
  // --------------------------------------------------------------------------
  logic signed [OFF_W-1:0] off_d [NUM_FACES][2];
  logic signed [OFF_W-1:0] off_q [NUM_FACES][2];

  always_comb begin
    logic [PROD_W-1:0] sp;
    for (int f = 0; f < NUM_FACES; f++) begin
      for (int j = 0; j < 2; j++) begin
        sp = axm_q[1][other_axis(2'(f / 2), 1'(j))].dneg ? (PROD_W'(0) - prod_q[f][j])
                                                          : prod_q[f][j];
        off_d[f][j] = OFF_W'($signed(sp) >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_OFF]) begin
      axm_q[2] <= axm_q[1];
      ok_q[2]  <= ok_q[1];
      big_q[1] <= big_q[0];
      off_q    <= off_d;
    end
  end

  // --------------------------------------------------------------------------
  // Range compare on both other axes and merge the six faces.
  // --------------------------------------------------------------------------
  logic hit_d;
  logic hit_q;

  always_comb begin
    logic       in_rng [2];
    logic [1:0] b;
    hit_d = 1'b0;
    for (int f = 0; f < NUM_FACES; f++) begin
      for (int j = 0; j < 2; j++) begin
        b         = other_axis(2'(f / 2), 1'(j));
        in_rng[j] = !big_q[1][f][j] &&
                    (off_q[f][j] >= OFF_W'(axm_q[2][b].lo_off)) &&
                    (off_q[f][j] <= OFF_W'(axm_q[2][b].hi_off));
      end
      hit_d = hit_d || (ok_q[2][f] && in_rng[0] && in_rng[1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_OUT]) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// ===== rtl/rbht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbht_checker: port-level assertions for the ray box hit test unit
// Tracks the number of words in flight and checks flow control behavior.
// ----------------------------------------------------------------------------
module rbht_checker
  import rbht_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_stall_o,
  input logic   out_valid_o,
  input logic   out_stall_i,
  input logic   hit_o
);

  localparam int OCC_W = $clog2(NUM_STAGES + 1);

  logic [OCC_W-1:0] occ_q;
  logic [OCC_W-1:0] occ_d;
  logic             in_take;
  logic             out_take;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;
  assign occ_d    = occ_q + OCC_W'(in_take) - OCC_W'(out_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // The input is held off only behind a stalled result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output is free");

  // The input is held off only when every stage holds a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (occ_q == OCC_W'(NUM_STAGES)))
    else $error("input stalled with room left in the pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(hit_o))
    else $error("result word changed while stalled");

endmodule

bind ray_box_hit_test_unit rbht_checker u_rbht_checker (.*);
